// ===== design/fbd_pkg.sv =====
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared constants, types and helpers of the framebuffer diff pixel emitter.
// ----------------------------------------------------------------------------
package fbd_pkg;

   // frame geometry
   localparam int ROWS          = 64;
   localparam int WORDS_PER_ROW = 4;
   localparam int BITS_PER_WORD = 32;
   localparam int ROWS_PER_PAGE = 8;
   localparam int HALF_COLUMNS  = 64;

   // field widths of the ports
   localparam int ROW_W    = 6;
   localparam int WIDX_W   = 2;
   localparam int COLUMN_W = 6;
   localparam int PAGE_W   = 3;
   localparam int MASK_W   = 8;

   localparam int DEPTH      = ROWS * WORDS_PER_ROW;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int LANE_W     = $clog2(BITS_PER_WORD);
   localparam int COL_W      = WIDX_W + LANE_W;
   localparam int SIDE_BIT   = $clog2(HALF_COLUMNS);
   localparam int ROWSEL_W   = $clog2(ROWS_PER_PAGE);

   // scan sequencer states
   localparam int STATE_W = 2;
   localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
   localparam logic [STATE_W-1:0] ST_READ = 2'd1;
   localparam logic [STATE_W-1:0] ST_EMIT = 2'd2;

   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [BITS_PER_WORD-1:0] word_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
   } shadow_req_type;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic               diff_zero;
   } scan_status_type;

   function automatic addr_type slot_of(logic [ROW_W-1:0] row, logic [WIDX_W-1:0] widx);
      int slot;
      slot = int'(row) * WORDS_PER_ROW + int'(widx);
      return ADDR_W'(slot);
   endfunction

   // index of the lowest set bit, zero when none is set
   function automatic logic [LANE_W-1:0] lowest_set(word_type w);
      logic [LANE_W-1:0] idx;
      idx = '0;
      for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
         if (w[i]) begin
            idx = LANE_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== design/fbd_ram.sv =====
// ----------------------------------------------------------------------------
// fbd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fbd_shadow.sv =====
// ----------------------------------------------------------------------------
// fbd_shadow
// Shadow copy of the displayed frame: RAM plus per-entry valid bits, so that
// an entry never written since reset reads as a cleared word.
// ----------------------------------------------------------------------------
module fbd_shadow (
   input  logic                    clock,
   input  logic                    reset,
   input  fbd_pkg::shadow_req_type mem_req,
   output fbd_pkg::word_type       rd_data
);

   logic [fbd_pkg::DEPTH-1:0] valid_ff;
   logic [fbd_pkg::DEPTH-1:0] valid_in;
   logic                      rd_valid_ff;
   logic                      rd_valid_in;
   fbd_pkg::word_type         ram_data;

   fbd_ram #(
      .WIDTH(fbd_pkg::BITS_PER_WORD),
      .DEPTH(fbd_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (ram_data),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (mem_req.wr_en) begin
         valid_in[mem_req.wr_addr] = 1'b1;
      end
      rd_valid_in = rd_valid_ff;
      if (mem_req.rd_en) begin
         rd_valid_in = valid_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? ram_data : '0;

endmodule

// ===== design/fbd_scan.sv =====
// ----------------------------------------------------------------------------
// fbd_scan
// Sequencer: reads the shadow word, writes back the new word, then walks the
// changed bits lowest first, emitting one pixel operation per unstalled cycle.
// ----------------------------------------------------------------------------
module fbd_scan (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fbd_pkg::ROW_W-1:0]         req_row,
   input  logic [fbd_pkg::WIDX_W-1:0]        req_word_index,
   input  logic [fbd_pkg::BITS_PER_WORD-1:0] req_pixel_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_side,
   output logic [fbd_pkg::COLUMN_W-1:0]      rsp_column,
   output logic [fbd_pkg::PAGE_W-1:0]        rsp_page,
   output logic [fbd_pkg::MASK_W-1:0]        rsp_bit_mask,
   output logic                              rsp_value,
   output logic                              rsp_last,
   output fbd_pkg::shadow_req_type           mem_req,
   input  fbd_pkg::word_type                 mem_rd_data,
   output fbd_pkg::scan_status_type          status
);

   logic [fbd_pkg::STATE_W-1:0] state_ff, state_in;
   logic [fbd_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [fbd_pkg::WIDX_W-1:0]  widx_ff, widx_in;
   fbd_pkg::word_type           fresh_ff, fresh_in;
   fbd_pkg::word_type           diff_ff, diff_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_side_ff, rsp_side_in;
   logic [fbd_pkg::COLUMN_W-1:0] rsp_column_ff, rsp_column_in;
   logic [fbd_pkg::PAGE_W-1:0]   rsp_page_ff, rsp_page_in;
   logic [fbd_pkg::MASK_W-1:0]   rsp_bit_mask_ff, rsp_bit_mask_in;
   logic                         rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                      accept;
   logic                      in_range;
   logic                      load_out;
   logic [fbd_pkg::LANE_W-1:0] lane;
   logic [fbd_pkg::COL_W-1:0]  col;
   fbd_pkg::word_type          diff_now;
   fbd_pkg::word_type          rest;

   assign req_stall = (state_ff != fbd_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign in_range  = (int'(req_row) < fbd_pkg::ROWS) &&
                      (int'(req_word_index) < fbd_pkg::WORDS_PER_ROW);

   assign diff_now = fresh_ff ^ mem_rd_data;
   assign lane     = fbd_pkg::lowest_set(diff_ff);
   assign rest     = diff_ff & (diff_ff - fbd_pkg::BITS_PER_WORD'(1));
   assign col      = {widx_ff, lane};
   assign load_out = (state_ff == fbd_pkg::ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in        = state_ff;
      row_in          = row_ff;
      widx_in         = widx_ff;
      fresh_in        = fresh_ff;
      diff_in         = diff_ff;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = fbd_pkg::slot_of(req_row, req_word_index);
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = fbd_pkg::slot_of(row_ff, widx_ff);
      mem_req.wr_data = fresh_ff;

      unique case (state_ff)
         fbd_pkg::ST_IDLE: begin
            // out-of-range items are dropped without touching the shadow
            if (accept && in_range) begin
               mem_req.rd_en = 1'b1;
               row_in        = req_row;
               widx_in       = req_word_index;
               fresh_in      = req_pixel_bits;
               state_in      = fbd_pkg::ST_READ;
            end
         end
         fbd_pkg::ST_READ: begin
            mem_req.wr_en = 1'b1;
            diff_in       = diff_now;
            state_in      = (diff_now == '0) ? fbd_pkg::ST_IDLE : fbd_pkg::ST_EMIT;
         end
         fbd_pkg::ST_EMIT: begin
            if (load_out) begin
               diff_in = rest;
               if (rest == '0) begin
                  state_in = fbd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = fbd_pkg::ST_IDLE;
         end
      endcase
   end

   // output register, refilled in the emit state whenever it is empty or being transferred
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_side_in     = rsp_side_ff;
      rsp_column_in   = rsp_column_ff;
      rsp_page_in     = rsp_page_ff;
      rsp_bit_mask_in = rsp_bit_mask_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_last_in     = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in    = 1'b1;
         rsp_side_in     = col[fbd_pkg::SIDE_BIT];
         rsp_column_in   = col[fbd_pkg::COLUMN_W-1:0];
         rsp_page_in     = row_ff[fbd_pkg::ROWSEL_W +: fbd_pkg::PAGE_W];
         rsp_bit_mask_in = fbd_pkg::MASK_W'(1) << row_ff[fbd_pkg::ROWSEL_W-1:0];
         rsp_value_in    = fresh_ff[lane];
         rsp_last_in     = (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff          <= row_in;
      widx_ff         <= widx_in;
      fresh_ff        <= fresh_in;
      diff_ff         <= diff_in;
      rsp_side_ff     <= rsp_side_in;
      rsp_column_ff   <= rsp_column_in;
      rsp_page_ff     <= rsp_page_in;
      rsp_bit_mask_ff <= rsp_bit_mask_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_side     = rsp_side_ff;
   assign rsp_column   = rsp_column_ff;
   assign rsp_page     = rsp_page_ff;
   assign rsp_bit_mask = rsp_bit_mask_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_last     = rsp_last_ff;

   assign status.state     = state_ff;
   assign status.diff_zero = (diff_ff == '0);

endmodule

// ===== design/framebuffer_diff_pixel_emitter.sv =====
// ----------------------------------------------------------------------------
// framebuffer_diff_pixel_emitter
// Compares 32-pixel frame words with a shadow of the display and emits one
// pixel operation per changed pixel.
// ----------------------------------------------------------------------------
// An item is one 32-pixel word (row, word index, pixels). It is compared with
// the shadow frame, held in a 256 x 32 synchronous RAM whose per-entry valid
// bits make it read as all zeros after reset (no clearing pass is needed).
// The shadow word is read when the item is taken; in the read state the new
// word is written back and the changed pixels are found, then one operation
// per changed pixel is emitted, each held back for as long as
// rsp_stall holds a full output register. Pixel operations come out lowest
// column first with rsp_last on the final one; an unchanged word or an
// out-of-range row or word index yields nothing. The next word is taken as
// soon as the final operation sits in the output register.
module framebuffer_diff_pixel_emitter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fbd_pkg::ROW_W-1:0]         req_row,
   input  logic [fbd_pkg::WIDX_W-1:0]        req_word_index,
   input  logic [fbd_pkg::BITS_PER_WORD-1:0] req_pixel_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_side,
   output logic [fbd_pkg::COLUMN_W-1:0]      rsp_column,
   output logic [fbd_pkg::PAGE_W-1:0]        rsp_page,
   output logic [fbd_pkg::MASK_W-1:0]        rsp_bit_mask,
   output logic                              rsp_value,
   output logic                              rsp_last
);

   fbd_pkg::shadow_req_type  mem_req;
   fbd_pkg::word_type        mem_rd_data;
   fbd_pkg::scan_status_type status;

   fbd_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_row        (req_row),
      .req_word_index (req_word_index),
      .req_pixel_bits (req_pixel_bits),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_side       (rsp_side),
      .rsp_column     (rsp_column),
      .rsp_page       (rsp_page),
      .rsp_bit_mask   (rsp_bit_mask),
      .rsp_value      (rsp_value),
      .rsp_last       (rsp_last),
      .mem_req        (mem_req),
      .mem_rd_data    (mem_rd_data),
      .status         (status)
   );

   fbd_shadow u_shadow (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

`ifndef SYNTHESIS
   // shadow is only written back in the cycle after its read
   a_write_in_read: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (status.state == fbd_pkg::ST_READ))
      else $error("shadow write outside read state");

   // read state is never held into the cycle after it
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (status.state == fbd_pkg::ST_READ) |=> (status.state != fbd_pkg::ST_READ))
      else $error("read state held more than one cycle");

   // emitting only while changed bits remain
   a_emit_has_work: assert property (@(posedge clock) disable iff (reset)
      (status.state == fbd_pkg::ST_EMIT) |-> !status.diff_zero)
      else $error("emit state with no changed bits");

   a_mask_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_bit_mask))
      else $error("bit mask not one-hot");
`endif

endmodule
